@@ hdl/pipa_pkg.sv @@
`default_nettype none

package pipa_pkg;

   // Default build: 64 stored vertices, 24-bit signed coordinates.
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 24;

   // Fixed field widths of the channels.
   localparam int SLOT_W   = 6;
   localparam int VCOUNT_W = 7;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   // Operation codes of an input item.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_X    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Z    = 3'd6;

   // Configuration seen by the core; box bounds are sign-extended to 32 bits.
   typedef struct packed {
      logic [VCOUNT_W-1:0]          vertex_count;
      logic signed [CSR_DATA_W-1:0] min_x;
      logic signed [CSR_DATA_W-1:0] max_x;
      logic signed [CSR_DATA_W-1:0] min_y;
      logic signed [CSR_DATA_W-1:0] max_y;
      logic signed [CSR_DATA_W-1:0] min_z;
      logic signed [CSR_DATA_W-1:0] max_z;
   } cfg_type;

   // Outcome of one edge leaving the edge unit.
   typedef struct packed {
      logic valid;
      logic hit;
   } edge_res_type;

endpackage

`default_nettype wire

@@ hdl/pipa_req_if.sv @@
`default_nettype none

interface pipa_req_if import pipa_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [SLOT_W-1:0]       vertex_slot;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;

   modport source (
      output valid, operation, vertex_slot, coord_x, coord_y, coord_z,
      input  ready
   );

   modport sink (
      input  valid, operation, vertex_slot, coord_x, coord_y, coord_z,
      output ready
   );

endinterface

`default_nettype wire

@@ hdl/pipa_rsp_if.sv @@
`default_nettype none

interface pipa_rsp_if import pipa_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                inside_res;
   logic                in_box;
   logic [VCOUNT_W-1:0] crossing_total;

   modport source (
      output valid, inside_res, in_box, crossing_total,
      input  ready
   );

   modport sink (
      input  valid, inside_res, in_box, crossing_total,
      output ready
   );

endinterface

`default_nettype wire

@@ hdl/pipa_csr.sv @@
`default_nettype none

module pipa_csr import pipa_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [VCOUNT_W-1:0]          count_ff;
   logic [VCOUNT_W-1:0]          count_in;
   logic signed [COORD_BITS-1:0] bound_ff [6];
   logic signed [COORD_BITS-1:0] bound_in [6];
   logic                         wr_en;
   logic [CSR_IDX_W-1:0]         idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   // Register write decode.
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < 6; i++) begin
         bound_in[i] = bound_ff[i];
      end
      if (wr_en) begin
         unique case (idx)
            REG_VERTEX_COUNT: count_in    = pwdata[VCOUNT_W-1:0];
            REG_BOX_MIN_X:    bound_in[0] = pwdata[COORD_BITS-1:0];
            REG_BOX_MAX_X:    bound_in[1] = pwdata[COORD_BITS-1:0];
            REG_BOX_MIN_Y:    bound_in[2] = pwdata[COORD_BITS-1:0];
            REG_BOX_MAX_Y:    bound_in[3] = pwdata[COORD_BITS-1:0];
            REG_BOX_MIN_Z:    bound_in[4] = pwdata[COORD_BITS-1:0];
            REG_BOX_MAX_Z:    bound_in[5] = pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < 6; i++) begin
            bound_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < 6; i++) begin
            bound_ff[i] <= bound_in[i];
         end
      end
   end

   // Read-back mux; bounds are returned sign-extended.
   always_comb begin
      unique case (idx)
         REG_VERTEX_COUNT: prdata = CSR_DATA_W'(count_ff);
         REG_BOX_MIN_X:    prdata = CSR_DATA_W'(bound_ff[0]);
         REG_BOX_MAX_X:    prdata = CSR_DATA_W'(bound_ff[1]);
         REG_BOX_MIN_Y:    prdata = CSR_DATA_W'(bound_ff[2]);
         REG_BOX_MAX_Y:    prdata = CSR_DATA_W'(bound_ff[3]);
         REG_BOX_MIN_Z:    prdata = CSR_DATA_W'(bound_ff[4]);
         REG_BOX_MAX_Z:    prdata = CSR_DATA_W'(bound_ff[5]);
         default:          prdata = '0;
      endcase
   end

   // Configuration handed to the core.
   assign cfg.vertex_count = count_ff;
   assign cfg.min_x        = CSR_DATA_W'(bound_ff[0]);
   assign cfg.max_x        = CSR_DATA_W'(bound_ff[1]);
   assign cfg.min_y        = CSR_DATA_W'(bound_ff[2]);
   assign cfg.max_y        = CSR_DATA_W'(bound_ff[3]);
   assign cfg.min_z        = CSR_DATA_W'(bound_ff[4]);
   assign cfg.max_z        = CSR_DATA_W'(bound_ff[5]);

endmodule

`default_nettype wire

@@ hdl/pipa_vertex_mem.sv @@
`default_nettype none

module pipa_vertex_mem import pipa_pkg::*; #(
   parameter int DEPTH  = MAX_VERTICES_DEF,
   parameter int DATA_W = 2 * COORD_BITS_DEF,
   parameter int ADDR_W = $clog2(MAX_VERTICES_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/pipa_edge_unit.sv @@
`default_nettype none

module pipa_edge_unit import pipa_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [COORD_BITS-1:0] px,
   input  wire logic signed [COORD_BITS-1:0] py,
   input  wire logic signed [COORD_BITS-1:0] ax,
   input  wire logic signed [COORD_BITS-1:0] ay,
   input  wire logic signed [COORD_BITS-1:0] bx,
   input  wire logic signed [COORD_BITS-1:0] by,
   output edge_res_type                      res
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   // Stage 1: range checks and differences.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_pre_ff, s1_pre_in;
   logic                 s1_vert_ff, s1_vert_in;
   logic                 s1_neg_ff, s1_neg_in;
   logic signed [DW-1:0] s1_pxa_ff, s1_pxa_in;
   logic signed [DW-1:0] s1_pya_ff, s1_pya_in;
   logic signed [DW-1:0] s1_dx_ff, s1_dx_in;
   logic signed [DW-1:0] s1_dy_ff, s1_dy_in;
   // Stage 2: the two cross products.
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_pre_ff, s2_pre_in;
   logic                 s2_vert_ff, s2_vert_in;
   logic                 s2_neg_ff, s2_neg_in;
   logic signed [PW-1:0] s2_lhs_ff, s2_lhs_in;
   logic signed [PW-1:0] s2_rhs_ff, s2_rhs_in;
   // Stage 3: verdict.
   edge_res_type         res_ff, res_in;
   logic signed [COORD_BITS-1:0] ylo, yhi, xhi;
   logic                 le_fwd, le_rev;

   // Edge bounds and the cheap rejections.
   always_comb begin
      ylo         = (ay < by) ? ay : by;
      yhi         = (ay < by) ? by : ay;
      xhi         = (ax < bx) ? bx : ax;
      s1_valid_in = in_valid;
      s1_pre_in   = (py > ylo) && (py <= yhi) && (px <= xhi) && (ay != by);
      s1_vert_in  = (ax == bx);
      s1_neg_in   = (by < ay);
      s1_pxa_in   = DW'(px) - DW'(ax);
      s1_pya_in   = DW'(py) - DW'(ay);
      s1_dx_in    = DW'(bx) - DW'(ax);
      s1_dy_in    = DW'(by) - DW'(ay);
   end

   // Exact intercept test: (px - ax) * dy against (py - ay) * dx.
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_pre_in   = s1_pre_ff;
      s2_vert_in  = s1_vert_ff;
      s2_neg_in   = s1_neg_ff;
      s2_lhs_in   = PW'(s1_pxa_ff) * PW'(s1_dy_ff);
      s2_rhs_in   = PW'(s1_pya_ff) * PW'(s1_dx_ff);
   end

   // A falling edge flips the inequality.
   always_comb begin
      le_fwd       = (s2_lhs_ff <= s2_rhs_ff);
      le_rev       = (s2_rhs_ff <= s2_lhs_ff);
      res_in.valid = s2_valid_ff;
      res_in.hit   = s2_valid_ff && s2_pre_ff &&
                     (s2_vert_ff || (s2_neg_ff ? le_rev : le_fwd));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         res_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         res_ff      <= res_in;
      end
      s1_pre_ff  <= s1_pre_in;
      s1_vert_ff <= s1_vert_in;
      s1_neg_ff  <= s1_neg_in;
      s1_pxa_ff  <= s1_pxa_in;
      s1_pya_ff  <= s1_pya_in;
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s2_pre_ff  <= s2_pre_in;
      s2_vert_ff <= s2_vert_in;
      s2_neg_ff  <= s2_neg_in;
      s2_lhs_ff  <= s2_lhs_in;
      s2_rhs_ff  <= s2_rhs_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

@@ hdl/point_in_prism_area_test_core.sv @@
// Channel  Dir  Handshake        Payload
// req      in   valid/ready      operation, vertex_slot, coord_x, coord_y, coord_z
// rsp      out  valid/ready      inside_res, in_box, crossing_total
// csr      in   APB write/read   vertex_count, box bounds (byte address 4*index)
//
// A vertex load gives no result item.
// A query walks n = min(vertex_count, MAX_VERTICES) vertices, none when n is zero:
// one vertex is read a cycle and the three-stage edge unit judges one edge a cycle.
// From accepting a query until its result is registered no item is taken; a result that
// waits on rsp.ready stalls only the final step of the next query, not the loads.
// Reset is synchronous; the vertex memory is not cleared.
`default_nettype none

module point_in_prism_area_test_core import pipa_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pipa_req_if.sink                   req,
   pipa_rsp_if.source                 rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VW    = 2 * COORD_BITS;
   localparam int ISS_W = VCOUNT_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in;
   logic signed [COORD_BITS-1:0] py_ff, py_in;
   logic signed [COORD_BITS-1:0] pz_ff, pz_in;
   logic [VCOUNT_W-1:0]          n_ff, n_in;
   logic [ISS_W-1:0]             issue_ff, issue_in;
   logic [VCOUNT_W-1:0]          done_ff, done_in;
   logic [VCOUNT_W-1:0]          cross_ff, cross_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         rd_first_ff, rd_first_in;
   logic [VW-1:0]                prev_ff, prev_in;
   logic                         box_ff, box_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_inside_ff, rsp_inside_in;
   logic                         rsp_box_ff, rsp_box_in;
   logic [VCOUNT_W-1:0]          rsp_cross_ff, rsp_cross_in;

   cfg_type                      cfg;
   edge_res_type                 edge_res;
   logic                         accept;
   logic                         mem_we;
   logic                         mem_re;
   logic [AW-1:0]                mem_raddr;
   logic [VW-1:0]                mem_rdata;
   logic signed [CSR_DATA_W-1:0] qx, qy, qz;

   // Configuration registers.
   pipa_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Vertex store, {y, x} per slot; a slot past capacity is dropped.
   assign accept = req.valid && req.ready;
   assign mem_we = accept && (req.operation == OP_LOAD) &&
                   (int'(req.vertex_slot) < MAX_VERTICES);

   pipa_vertex_mem #(
      .DEPTH  (MAX_VERTICES),
      .DATA_W (VW),
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req.vertex_slot)),
      .wr_data ({req.coord_y, req.coord_x}),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Shared edge unit; consecutive vertices from the read stream form an edge.
   pipa_edge_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff && !rd_first_ff),
      .px       (px_ff),
      .py       (py_ff),
      .ax       (prev_ff[COORD_BITS-1:0]),
      .ay       (prev_ff[VW-1:COORD_BITS]),
      .bx       (mem_rdata[COORD_BITS-1:0]),
      .by       (mem_rdata[VW-1:COORD_BITS]),
      .res      (edge_res)
   );

   assign req.ready = (state_ff == S_IDLE);

   // Point widened to the width of the bounds.
   assign qx = CSR_DATA_W'(px_ff);
   assign qy = CSR_DATA_W'(py_ff);
   assign qz = CSR_DATA_W'(pz_ff);

   // Sequencer: reads vertices 0..n-1 and then vertex 0 again for the closing edge.
   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      done_in       = done_ff;
      cross_in      = cross_ff;
      box_in        = box_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_box_in    = rsp_box_ff;
      rsp_cross_in  = rsp_cross_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      mem_re        = 1'b0;
      mem_raddr     = (issue_ff == ISS_W'(n_ff)) ? '0 : AW'(issue_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req.operation == OP_QUERY)) begin
               px_in    = req.coord_x;
               py_in    = req.coord_y;
               pz_in    = req.coord_z;
               n_in     = (int'(cfg.vertex_count) > MAX_VERTICES) ?
                          VCOUNT_W'(MAX_VERTICES) : cfg.vertex_count;
               issue_in = '0;
               done_in  = '0;
               cross_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            box_in = (qx >= $signed(cfg.min_x)) && (qx <= $signed(cfg.max_x)) &&
                     (qy >= $signed(cfg.min_y)) && (qy <= $signed(cfg.max_y)) &&
                     (qz >= $signed(cfg.min_z)) && (qz <= $signed(cfg.max_z));
            if ((n_ff != '0) && (issue_ff <= ISS_W'(n_ff))) begin
               mem_re   = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
            if (edge_res.valid) begin
               done_in  = done_ff + 1'b1;
               cross_in = cross_ff + VCOUNT_W'(edge_res.hit);
            end
            if (done_ff == n_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = box_ff && cross_ff[0];
               rsp_box_in    = box_ff;
               rsp_cross_in  = cross_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rd_valid_in = mem_re;
      rd_first_in = mem_re && (issue_ff == '0);
      prev_in     = rd_valid_ff ? mem_rdata : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rd_first_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         issue_ff     <= '0;
         done_ff      <= '0;
         cross_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rd_first_ff  <= rd_first_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         issue_ff     <= issue_in;
         done_ff      <= done_in;
         cross_ff     <= cross_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      pz_ff         <= pz_in;
      prev_ff       <= prev_in;
      box_ff        <= box_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_box_ff    <= rsp_box_in;
      rsp_cross_ff  <= rsp_cross_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.inside_res     = rsp_inside_ff;
   assign rsp.in_box         = rsp_box_ff;
   assign rsp.crossing_total = rsp_cross_ff;

   // No more edges are judged than the polygon has.
   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (done_ff <= n_ff))
      else $error("edge count ran past the vertex count");

   // Crossings never outnumber the edges judged so far.
   a_cross_bounded: assert property (@(posedge clock) disable iff (reset)
      (cross_ff <= done_ff))
      else $error("crossing count exceeds judged edges");

   // A fresh result never reports more crossings than edges.
   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_cross_ff <= n_ff))
      else $error("result crossing total exceeds edge count");

endmodule

`default_nettype wire

@@ test/area_verdict_checker.sv @@
module area_verdict_checker import pipa_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pipa_req_if                        req,
   pipa_rsp_if                        rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         pending,
   output int                         errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = MAX_VERTICES_DEF;
   localparam int CB = COORD_BITS_DEF;

   typedef struct packed {
      logic                inside_res;
      logic                in_box;
      logic [VCOUNT_W-1:0] crossing_total;
   } verdict_type;

   // Shadow of the polygon store and of the registers.
   logic signed [CB-1:0] vert_x [NV];
   logic signed [CB-1:0] vert_y [NV];
   logic [VCOUNT_W-1:0]  poly_count;
   logic signed [CB-1:0] box_lo [3];
   logic signed [CB-1:0] box_hi [3];

   // Verdicts of accepted queries whose result item has not come yet.
   verdict_type awaited [$];

   // True when the ray from (px, py) towards +x crosses the edge a-b.
   function automatic bit edge_counts(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
      longint ylo, yhi, xhi, dy;
      ylo = (ay < by) ? ay : by;
      yhi = (ay < by) ? by : ay;
      xhi = (ax < bx) ? bx : ax;
      dy  = by - ay;
      if (dy == 0 || py <= ylo || py > yhi || px > xhi) return 1'b0;
      if (ax == bx) return 1'b1;
      // px - ax <= (py - ay) * (bx - ax) / dy, cross-multiplied so that no rounding occurs.
      if (dy > 0) return (px - ax) * dy <= (py - ay) * (bx - ax);
      return (py - ay) * (bx - ax) <= (px - ax) * dy;
   endfunction

   // Box test and crossing count for one query point.
   function automatic verdict_type judge_point(logic signed [CB-1:0] px, py, pz);
      verdict_type v;
      int          used, hits, nxt;
      logic        boxed;
      boxed = px >= box_lo[0] && px <= box_hi[0] &&
              py >= box_lo[1] && py <= box_hi[1] &&
              pz >= box_lo[2] && pz <= box_hi[2];
      used = (poly_count > NV) ? NV : int'(poly_count);
      hits = 0;
      for (int i = 0; i < used; i++) begin
         nxt = (i + 1 == used) ? 0 : i + 1;
         if (edge_counts(px, py, vert_x[i], vert_y[i], vert_x[nxt], vert_y[nxt])) hits++;
      end
      v.in_box         = boxed;
      v.inside_res     = boxed && hits[0];
      v.crossing_total = (hits > 127) ? 7'd127 : hits[VCOUNT_W-1:0];
      return v;
   endfunction

   task automatic note_miss(input string what, input int want, input int got);
      errors++;
      if (errors <= 10) $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   // Everything is sampled at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         poly_count = '0;
         for (int k = 0; k < 3; k++) begin
            box_lo[k] = '0;
            box_hi[k] = '0;
         end
         awaited.delete();
      end else begin
         // Register writes.
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_VERTEX_COUNT: poly_count = pwdata[VCOUNT_W-1:0];
               REG_BOX_MIN_X:    box_lo[0]  = pwdata[CB-1:0];
               REG_BOX_MAX_X:    box_hi[0]  = pwdata[CB-1:0];
               REG_BOX_MIN_Y:    box_lo[1]  = pwdata[CB-1:0];
               REG_BOX_MAX_Y:    box_hi[1]  = pwdata[CB-1:0];
               REG_BOX_MIN_Z:    box_lo[2]  = pwdata[CB-1:0];
               REG_BOX_MAX_Z:    box_hi[2]  = pwdata[CB-1:0];
               default: ;
            endcase
         end
         // Result items are matched against the oldest awaited verdict.
         if (rsp.valid && rsp.ready) begin
            if (awaited.size() == 0) begin
               note_miss("result item with no query waiting", 0, 1);
            end else begin
               want = awaited.pop_front();
               if (rsp.inside_res !== want.inside_res)
                  note_miss("inside_res", want.inside_res, rsp.inside_res);
               if (rsp.in_box !== want.in_box)
                  note_miss("in_box", want.in_box, rsp.in_box);
               if (rsp.crossing_total !== want.crossing_total)
                  note_miss("crossing_total", want.crossing_total, rsp.crossing_total);
            end
         end
         // Input items: loads update the shadow store, queries are predicted.
         if (req.valid && req.ready) begin
            if (req.operation == OP_LOAD) begin
               vert_x[req.vertex_slot] = req.coord_x;
               vert_y[req.vertex_slot] = req.coord_y;
            end else begin
               awaited = {awaited, judge_point(req.coord_x, req.coord_y, req.coord_z)};
            end
         end
      end
      pending = awaited.size();
   end

endmodule

@@ test/tb_point_in_prism_area_test_core.sv @@
module tb_point_in_prism_area_test_core import pipa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV            = MAX_VERTICES_DEF;
   localparam int CB            = COORD_BITS_DEF;
   localparam int RANDOM_ITEMS  = 650;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 600000;

   localparam logic signed [CB-1:0] C_MIN = -(2 ** (CB - 1));
   localparam logic signed [CB-1:0] C_MAX = 2 ** (CB - 1) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pipa_req_if req_ch ();
   pipa_rsp_if rsp_ch ();

   int awaited_count;
   int miss_count;
   int items_sent  = 0;
   int burst_left  = 0;
   int hold_left   = 0;
   int cycle_count = 0;
   bit gaps_on     = 1'b1;
   bit stalls_on   = 1'b1;

   // Polygon as laid out by the stimulus, used only to aim query points.
   logic signed [CB-1:0] shape_x [NV];
   logic signed [CB-1:0] shape_y [NV];

   point_in_prism_area_test_core uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   area_verdict_checker chk (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .pready  (pready),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .pending (awaited_count),
      .errors  (miss_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result receiver: stalls of random length, switched off in some phases.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= $urandom_range(0, 5);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // A span of zero means the whole coordinate range.
   function automatic logic signed [CB-1:0] pick_coord(input int span);
      if (span == 0) return CB'($urandom);
      return CB'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Presents one item and waits until it is accepted; bursts end in a random gap.
   task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic signed [CB-1:0] x, y, z);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.vertex_slot <= slot;
      req_ch.coord_x     <= x;
      req_ch.coord_y     <= y;
      req_ch.coord_z     <= z;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Stops sending and waits until every awaited result item has arrived.
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_box(input logic signed [CB-1:0] x0, x1, y0, y1, z0, z1);
      csr_write(REG_BOX_MIN_X, CSR_DATA_W'(x0));
      csr_write(REG_BOX_MAX_X, CSR_DATA_W'(x1));
      csr_write(REG_BOX_MIN_Y, CSR_DATA_W'(y0));
      csr_write(REG_BOX_MAX_Y, CSR_DATA_W'(y1));
      csr_write(REG_BOX_MIN_Z, CSR_DATA_W'(z0));
      csr_write(REG_BOX_MAX_Z, CSR_DATA_W'(z1));
   endtask

   // One setting of the registers: a fresh polygon, then queries aimed at it.
   task automatic run_phase(input int p);
      int                   vcount, span, eff, used, queries, pick, a, b, t, axis;
      longint               dx, dy;
      logic signed [CB-1:0] lo [3];
      logic signed [CB-1:0] hi [3];
      logic signed [CB-1:0] swap, x, y, z;
      logic [SLOT_W-1:0]    slot;
      case (p)
         0:       vcount = NV;
         1:       vcount = 127;
         2:       vcount = 0;
         3:       vcount = 1;
         4:       vcount = 2;
         default: vcount = (p % 5 == 0) ? 40 : $urandom_range(3, 16);
      endcase
      // Tiny spans force shared heights, vertical edges and exact intercepts.
      case (p % 5)
         0:       span = 4;
         1:       span = 256;
         2:       span = 0;
         3:       span = 3000;
         default: span = 16;
      endcase
      eff       = (span == 0) ? int'(C_MAX) : span;
      used      = (vcount > NV) ? NV : vcount;
      queries   = $urandom_range(25, 45);
      gaps_on   = (p % 3 != 1);
      stalls_on = (p % 4 != 2);

      // Full box, a box trimmed inside the span, or a trimmed box with one axis inverted.
      for (int k = 0; k < 3; k++) begin
         if (p % 3 == 0) begin
            lo[k] = C_MIN;
            hi[k] = C_MAX;
         end else begin
            lo[k] = CB'(int'($urandom_range(0, eff / 4)) - eff);
            hi[k] = CB'(eff - int'($urandom_range(0, eff / 4)));
         end
      end
      if (p % 3 == 2) begin
         axis     = $urandom_range(0, 2);
         swap     = lo[axis];
         lo[axis] = hi[axis];
         hi[axis] = swap;
      end

      drain();
      set_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
      csr_write(REG_VERTEX_COUNT, vcount);

      // Every slot in use is written before the first query reads it.
      for (int k = 0; k < used; k++) begin
         shape_x[k] = pick_coord(span);
         shape_y[k] = pick_coord(span);
         send_item(OP_LOAD, SLOT_W'(k), shape_x[k], shape_y[k], pick_coord(0));
      end

      for (int q = 0; q < queries; q++) begin
         if (q == queries / 2) drain();
         pick = $urandom_range(0, 11);
         a    = (used == 0) ? 0 : $urandom_range(0, used - 1);
         b    = (a + 1 == used) ? 0 : a + 1;
         x    = pick_coord(span);
         y    = pick_coord(span);
         z    = ($urandom_range(0, 7) == 0) ? pick_coord(0) : pick_coord(span);
         slot = SLOT_W'($urandom);
         if (pick == 0) begin
            // Reload of a random slot; slots in use stay written.
            if (slot < used) begin
               shape_x[slot] = x;
               shape_y[slot] = y;
            end
            send_item(OP_LOAD, slot, x, y, z);
         end else begin
            if (used > 0) begin
               case (pick)
                  1, 2: begin
                     x = shape_x[a];
                     y = shape_y[a];
                  end
                  3, 4, 5: begin
                     t  = $urandom_range(0, 4);
                     dx = shape_x[b] - shape_x[a];
                     dy = shape_y[b] - shape_y[a];
                     x  = CB'(shape_x[a] + dx * t / 4);
                     y  = CB'(shape_y[a] + dy * t / 4);
                  end
                  6:       y = shape_y[a];
                  7: begin
                     x = pick_coord(0);
                     y = pick_coord(0);
                  end
                  default: ;
               endcase
            end
            send_item(OP_QUERY, slot, x, y, z);
         end
      end
   endtask

   initial begin : stimulus
      int base;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_LOAD;
      req_ch.vertex_slot = '0;
      req_ch.coord_x     = '0;
      req_ch.coord_y     = '0;
      req_ch.coord_z     = '0;
      rsp_ch.ready       = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Registers at reset: no vertices and a box collapsed to the origin.
      send_item(OP_QUERY, '0, 0, 0, 0);
      send_item(OP_QUERY, '1, 1, -1, 0);
      send_item(OP_LOAD, '1, C_MAX, C_MIN, -1);

      // Square on the extreme corners inside the widest box.
      drain();
      set_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
      csr_write(REG_VERTEX_COUNT, 4);
      send_item(OP_LOAD, 0, C_MIN, C_MIN, 0);
      send_item(OP_LOAD, 1, C_MAX, C_MIN, 0);
      send_item(OP_LOAD, 2, C_MAX, C_MAX, 0);
      send_item(OP_LOAD, 3, C_MIN, C_MAX, 0);
      send_item(OP_QUERY, '0, 0, 0, C_MIN);
      send_item(OP_QUERY, '0, C_MIN, C_MIN, C_MAX);
      send_item(OP_QUERY, '0, C_MAX, C_MAX, 0);
      send_item(OP_QUERY, '0, C_MIN, 0, 0);
      send_item(OP_QUERY, '0, C_MAX, 0, 0);

      // A single vertex gives only a degenerate edge.
      drain();
      csr_write(REG_VERTEX_COUNT, 1);
      send_item(OP_QUERY, '0, 0, 0, 0);

      // Triangle with a horizontal, a slanted and a vertical edge.
      drain();
      csr_write(REG_VERTEX_COUNT, 3);
      send_item(OP_LOAD, 0, 0, 0, 0);
      send_item(OP_LOAD, 1, 512, 0, 0);
      send_item(OP_LOAD, 2, 0, 512, 0);
      send_item(OP_QUERY, '0, 256, 256, 0);
      send_item(OP_QUERY, '0, 257, 256, 0);
      send_item(OP_QUERY, '0, -1, 256, 0);
      send_item(OP_QUERY, '0, 0, 0, 0);
      send_item(OP_QUERY, '0, 100, 512, 0);

      // Inverted x bounds make every point fall outside the box.
      drain();
      set_box(1, 0, C_MIN, C_MAX, C_MIN, C_MAX);
      send_item(OP_QUERY, '0, 0, 100, 0);

      base = items_sent;
      for (int p = 0; items_sent - base < RANDOM_ITEMS; p++) run_phase(p);

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (miss_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
